// ----- rtl/u8w_pkg.sv -----
// Shared types, constants and the width range table of the UTF-8 display width tracker.
package u8w_pkg;

    // Default width of the saturating column sums
    localparam int TOTAL_BITS_DEF = 16;

    // Two-entry queue between decoder and classifier
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_NARROW_AMBIGUOUS = 2'd0;
    localparam logic [1:0] CFG_EMOJI_COLUMNS    = 2'd1;
    localparam logic [1:0] CFG_MAX_COLUMNS      = 2'd2;

    // Configuration reset values
    localparam logic        NARROW_RST  = 1'b0;
    localparam logic [1:0]  EMOJI_RST   = 2'd2;
    localparam logic [11:0] MAX_COL_RST = 12'd80;

    // Byte prefixes
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Column codes
    localparam logic signed [2:0] COLS_CTRL = 3'sb111;
    localparam logic signed [2:0] COLS_ZERO = 3'sd0;
    localparam logic signed [2:0] COLS_ONE  = 3'sd1;
    localparam logic signed [2:0] COLS_TWO  = 3'sd2;

    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_TWO,
        KIND_AMB,
        KIND_EMO
    } t_kind;

    typedef struct packed {
        logic [20:0] lo;
        logic [20:0] hi;
        t_kind       kind;
    } t_span;

    // Decoded character handed from the decoder to the back end
    typedef struct packed {
        logic [20:0] code_point;
        logic        well_formed;
        logic        final_char;
    } t_char_evt;

    // Configuration registers as seen by the back end
    typedef struct packed {
        logic        narrow_ambiguous;
        logic [1:0]  emoji_columns;
        logic [11:0] max_columns;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic signed [2:0]  char_width;
        logic [20:0]        code_point;
        logic               well_formed;
        logic signed [15:0] running_width;
        logic               keep;
        logic               string_end;
    } t_result;

    // Ordered ranges, first match wins
    localparam int NUM_SPANS = 80;
    localparam t_span SPANS [NUM_SPANS] = '{
        '{21'h00300, 21'h0036F, KIND_ZERO}, '{21'h01AB0, 21'h01AFF, KIND_ZERO},
        '{21'h01DC0, 21'h01DFF, KIND_ZERO}, '{21'h020D0, 21'h020FF, KIND_ZERO},
        '{21'h0FE20, 21'h0FE2F, KIND_ZERO}, '{21'h00483, 21'h00489, KIND_ZERO},
        '{21'h0064B, 21'h0065F, KIND_ZERO}, '{21'h00670, 21'h00670, KIND_ZERO},
        '{21'h006D6, 21'h006DC, KIND_ZERO}, '{21'h006DF, 21'h006E4, KIND_ZERO},
        '{21'h006E7, 21'h006E8, KIND_ZERO}, '{21'h006EA, 21'h006ED, KIND_ZERO},
        '{21'h00900, 21'h00903, KIND_ZERO}, '{21'h0093A, 21'h0093C, KIND_ZERO},
        '{21'h0093E, 21'h0094F, KIND_ZERO}, '{21'h00951, 21'h00957, KIND_ZERO},
        '{21'h00962, 21'h00963, KIND_ZERO}, '{21'h00591, 21'h005BD, KIND_ZERO},
        '{21'h005BF, 21'h005BF, KIND_ZERO}, '{21'h005C1, 21'h005C2, KIND_ZERO},
        '{21'h005C4, 21'h005C5, KIND_ZERO}, '{21'h005C7, 21'h005C7, KIND_ZERO},
        '{21'h00E31, 21'h00E31, KIND_ZERO}, '{21'h00E34, 21'h00E3A, KIND_ZERO},
        '{21'h00E47, 21'h00E4E, KIND_ZERO}, '{21'h0200B, 21'h0200F, KIND_ZERO},
        '{21'h0202A, 21'h0202E, KIND_ZERO}, '{21'h02060, 21'h02063, KIND_ZERO},
        '{21'h02066, 21'h0206F, KIND_ZERO}, '{21'h0FE00, 21'h0FE0F, KIND_ZERO},
        '{21'hE0100, 21'hE01EF, KIND_ZERO}, '{21'h0061C, 21'h0061C, KIND_ZERO},
        '{21'h0115F, 21'h01160, KIND_ZERO}, '{21'h017B4, 21'h017B5, KIND_ZERO},
        '{21'h0180B, 21'h0180D, KIND_ZERO}, '{21'h0180F, 21'h0180F, KIND_ZERO},
        '{21'h0FEFF, 21'h0FEFF, KIND_ZERO},
        '{21'h01100, 21'h0115F, KIND_TWO}, '{21'h01161, 21'h011FF, KIND_TWO},
        '{21'h0A960, 21'h0A97C, KIND_TWO}, '{21'h0D7B0, 21'h0D7C6, KIND_TWO},
        '{21'h0D7CB, 21'h0D7FB, KIND_TWO}, '{21'h02E80, 21'h02EF3, KIND_TWO},
        '{21'h02F00, 21'h02FD5, KIND_TWO}, '{21'h02FF0, 21'h02FFB, KIND_TWO},
        '{21'h03000, 21'h0303E, KIND_TWO}, '{21'h0303F, 21'h0303F, KIND_ONE},
        '{21'h03040, 21'h030FF, KIND_TWO}, '{21'h03100, 21'h0312F, KIND_TWO},
        '{21'h031A0, 21'h031E3, KIND_TWO}, '{21'h03400, 21'h04DBF, KIND_TWO},
        '{21'h04E00, 21'h09FFF, KIND_TWO}, '{21'h0A000, 21'h0A48C, KIND_TWO},
        '{21'h0A490, 21'h0A4C6, KIND_TWO}, '{21'h0AC00, 21'h0D7A3, KIND_TWO},
        '{21'h0F900, 21'h0FAFF, KIND_TWO}, '{21'h0FE10, 21'h0FE19, KIND_TWO},
        '{21'h0FE30, 21'h0FE52, KIND_TWO}, '{21'h0FE54, 21'h0FE66, KIND_TWO},
        '{21'h0FE68, 21'h0FE6B, KIND_TWO}, '{21'h0FF01, 21'h0FF60, KIND_TWO},
        '{21'h0FFE0, 21'h0FFE6, KIND_TWO}, '{21'h02329, 21'h0232A, KIND_TWO},
        '{21'h000A2, 21'h000A3, KIND_AMB}, '{21'h000A5, 21'h000A5, KIND_AMB},
        '{21'h000AC, 21'h000AC, KIND_AMB}, '{21'h020A9, 21'h020A9, KIND_AMB},
        '{21'h00391, 21'h003A9, KIND_AMB}, '{21'h003B1, 21'h003C9, KIND_AMB},
        '{21'h003D0, 21'h003F5, KIND_AMB},
        '{21'h20000, 21'h2A6DF, KIND_TWO}, '{21'h2A700, 21'h2EBEF, KIND_TWO},
        '{21'h2F800, 21'h2FA1F, KIND_TWO}, '{21'h30000, 21'h323AF, KIND_TWO},
        '{21'h02600, 21'h027BF, KIND_AMB}, '{21'h02300, 21'h023FF, KIND_AMB},
        '{21'h025A0, 21'h025FF, KIND_AMB},
        '{21'h1F300, 21'h1F64F, KIND_EMO}, '{21'h1F680, 21'h1F6FF, KIND_EMO},
        '{21'h1F900, 21'h1FAFF, KIND_EMO}
    };

    // Terminal columns of a well-formed code point
    function automatic logic signed [2:0] char_cols(input logic [20:0] cp,
                                                     input logic        narrow,
                                                     input logic [1:0]  emoji);
        t_kind             kind;
        logic signed [2:0] cols;
        kind = KIND_ONE;
        // Walk backwards so the earliest matching range is the one left standing
        for (int i = NUM_SPANS - 1; i >= 0; i--) begin
            if (cp >= SPANS[i].lo && cp <= SPANS[i].hi) begin
                kind = SPANS[i].kind;
            end
        end
        case (kind)
            KIND_ZERO: cols = COLS_ZERO;
            KIND_ONE:  cols = COLS_ONE;
            KIND_TWO:  cols = COLS_TWO;
            KIND_AMB:  cols = narrow ? COLS_ONE : COLS_TWO;
            KIND_EMO:  cols = (emoji == 2'd3) ? COLS_TWO : $signed({1'b0, emoji});
            default:   cols = COLS_ONE;
        endcase
        if (cp == 21'd0) begin
            cols = COLS_ZERO;
        end else if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
            cols = COLS_CTRL;
        end
        return cols;
    endfunction

endpackage

// ----- rtl/u8w_front.sv -----
// Byte decoder: assembles UTF-8 sequences into characters, one byte per cycle while the queue has room.
module u8w_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_final,
    output logic                 o_evt_valid,
    input  logic                 i_evt_ready,
    output u8w_pkg::t_char_evt   o_evt
);

    logic [7:0]  r_lead, n_lead;
    logic [1:0]  r_rem, n_rem;
    logic [20:0] r_part, n_part;
    logic        r_ok, n_ok;

    logic        emit;
    logic [20:0] part_shift;
    logic        cont_ok;
    logic [1:0]  rem_dec;
    logic        accept;

    assign o_ready = i_evt_ready;
    assign accept  = i_valid && i_evt_ready;

    assign part_shift = {r_part[14:0], i_byte[5:0]};
    assign cont_ok    = r_ok && (i_byte[7:6] == u8w_pkg::CONT_TAG);
    assign rem_dec    = r_rem - 2'd1;

    // Decode step
    always_comb begin
        n_lead = r_lead;
        n_rem  = r_rem;
        n_part = r_part;
        n_ok   = r_ok;
        emit   = 1'b0;
        o_evt.code_point  = {13'd0, i_byte};
        o_evt.well_formed = 1'b0;
        o_evt.final_char  = i_final;
        if (r_rem == 2'd0) begin
            if (!i_byte[7]) begin
                emit = 1'b1;
                o_evt.well_formed = 1'b1;
            end else if (i_byte[7:5] == u8w_pkg::LEAD2_TAG ||
                         i_byte[7:4] == u8w_pkg::LEAD3_TAG ||
                         i_byte[7:3] == u8w_pkg::LEAD4_TAG) begin
                // Multi-byte lead; a final lead is a cut-off character
                if (i_final) begin
                    emit = 1'b1;
                end else begin
                    n_lead = i_byte;
                    n_ok   = 1'b1;
                    if (i_byte[7:5] == u8w_pkg::LEAD2_TAG) begin
                        n_rem  = 2'd1;
                        n_part = {16'd0, i_byte[4:0]};
                    end else if (i_byte[7:4] == u8w_pkg::LEAD3_TAG) begin
                        n_rem  = 2'd2;
                        n_part = {17'd0, i_byte[3:0]};
                    end else begin
                        n_rem  = 2'd3;
                        n_part = {18'd0, i_byte[2:0]};
                    end
                end
            end else begin
                // Invalid lead: one byte, malformed
                emit = 1'b1;
            end
        end else begin
            if (rem_dec == 2'd0) begin
                emit = 1'b1;
                o_evt.well_formed = cont_ok;
                o_evt.code_point  = cont_ok ? part_shift : {13'd0, r_lead};
                n_rem  = 2'd0;
                n_lead = 8'd0;
                n_part = 21'd0;
                n_ok   = 1'b1;
            end else if (i_final) begin
                emit = 1'b1;
                o_evt.code_point = {13'd0, r_lead};
            end else begin
                n_rem  = rem_dec;
                n_part = part_shift;
                n_ok   = cont_ok;
            end
        end
        // End of string clears the decoder
        if (i_final) begin
            n_lead = 8'd0;
            n_rem  = 2'd0;
            n_part = 21'd0;
            n_ok   = 1'b1;
        end
    end

    assign o_evt_valid = i_valid && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'd0;
            r_rem  <= 2'd0;
            r_part <= 21'd0;
            r_ok   <= 1'b1;
        end else if (accept) begin
            r_lead <= n_lead;
            r_rem  <= n_rem;
            r_part <= n_part;
            r_ok   <= n_ok;
        end
    end

endmodule

// ----- rtl/u8w_queue.sv -----
// Short character queue between the decoder and the width back end.
module u8w_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_valid,
    output logic               o_wr_ready,
    input  u8w_pkg::t_char_evt i_wr_data,
    output logic               o_rd_valid,
    input  logic               i_rd_ready,
    output u8w_pkg::t_char_evt o_rd_data
);

    u8w_pkg::t_char_evt r_mem [u8w_pkg::Q_DEPTH];
    logic [u8w_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [u8w_pkg::Q_AW:0]   r_count, n_count;
    logic                     push, pop;

    assign o_wr_ready = (r_count != u8w_pkg::Q_AW'(0) + (u8w_pkg::Q_AW + 1)'(u8w_pkg::Q_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/u8w_back.sv -----
// Back end: range-table width lookup, then saturating sums, keep rule and result register.
module u8w_back #(
    parameter int TOTAL_BITS = u8w_pkg::TOTAL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8w_pkg::t_cfg      i_cfg,
    input  logic               i_evt_valid,
    output logic               o_evt_ready,
    input  u8w_pkg::t_char_evt i_evt,
    output logic               o_valid,
    input  logic               i_ready,
    output u8w_pkg::t_result   o_result
);

    localparam int CW    = (TOTAL_BITS + 1 > 13) ? TOTAL_BITS + 1 : 13;
    localparam int EXT_W = (TOTAL_BITS > 16) ? TOTAL_BITS : 16;
    localparam logic signed [TOTAL_BITS-1:0] SAT_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic signed [TOTAL_BITS-1:0] SAT_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

    // Lookup stage
    logic               r_a_valid;
    logic signed [2:0]  r_a_width;
    logic [20:0]        r_a_cp;
    logic               r_a_ok;
    logic               r_a_fin;
    logic               a_ready;
    logic signed [2:0]  a_width;

    // Sum stage state
    logic signed [TOTAL_BITS-1:0] r_total, n_total;
    logic signed [TOTAL_BITS-1:0] r_kept, n_kept;
    logic                         r_over, n_over;
    logic                         b_ready, b_take;
    logic signed [TOTAL_BITS:0]   tot_sum, kept_sum;
    logic signed [CW-1:0]         fit_sum, limit;
    logic                         keep;
    logic signed [TOTAL_BITS-1:0] tot_sat, kept_sat;
    logic signed [EXT_W-1:0]      tot_ext;

    u8w_pkg::t_result r_out;
    logic             r_out_valid;

    assign b_ready     = !r_out_valid || i_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign o_evt_ready = a_ready;
    assign b_take      = r_a_valid && b_ready;

    // Width of the character; malformed counts as one column
    assign a_width = i_evt.well_formed
                   ? u8w_pkg::char_cols(i_evt.code_point, i_cfg.narrow_ambiguous,
                                        i_cfg.emoji_columns)
                   : u8w_pkg::COLS_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_evt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_evt_valid) begin
            r_a_width <= a_width;
            r_a_cp    <= i_evt.code_point;
            r_a_ok    <= i_evt.well_formed;
            r_a_fin   <= i_evt.final_char;
        end
    end

    // Saturating sums and keep decision
    assign tot_sum  = (TOTAL_BITS+1)'(r_total) + (TOTAL_BITS+1)'(r_a_width);
    assign kept_sum = (TOTAL_BITS+1)'(r_kept) + (TOTAL_BITS+1)'(r_a_width);
    assign fit_sum  = CW'(r_kept) + CW'(r_a_width);
    assign limit    = $signed(CW'(i_cfg.max_columns));
    assign keep     = !r_over && (i_cfg.max_columns != 12'd0) && (fit_sum <= limit);

    assign tot_sat  = (tot_sum[TOTAL_BITS] != tot_sum[TOTAL_BITS-1])
                    ? (tot_sum[TOTAL_BITS] ? SAT_MIN : SAT_MAX)
                    : tot_sum[TOTAL_BITS-1:0];
    assign kept_sat = (kept_sum[TOTAL_BITS] != kept_sum[TOTAL_BITS-1])
                    ? (kept_sum[TOTAL_BITS] ? SAT_MIN : SAT_MAX)
                    : kept_sum[TOTAL_BITS-1:0];
    assign tot_ext  = EXT_W'(tot_sat);

    always_comb begin
        n_total = tot_sat;
        n_kept  = keep ? kept_sat : r_kept;
        n_over  = r_over || !keep;
        // A string's last character resets the sums
        if (r_a_fin) begin
            n_total = '0;
            n_kept  = '0;
            n_over  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_kept      <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b_take) begin
                r_total <= n_total;
                r_kept  <= n_kept;
                r_over  <= n_over;
            end
            if (b_ready) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (b_take) begin
            r_out.char_width    <= r_a_width;
            r_out.code_point    <= r_a_cp;
            r_out.well_formed   <= r_a_ok;
            r_out.running_width <= tot_ext[15:0];
            r_out.keep          <= keep;
            r_out.string_end    <= r_a_fin;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- rtl/utf8_display_width_tracker.sv -----
// Top level of the UTF-8 display width tracker: stream ports, configuration registers.
// Takes one string byte per cycle and gives one result item per finished
// character, with its column width, code point, a saturating running width
// and a keep flag for truncation to a column limit; the last byte of a string
// (tlast) also finishes a cut-off character and restarts the sums. The sustained rate
// is one byte per cycle while the result output is not stalled. After its last byte
// is accepted, a character's result is registered in turn: the decoder writes it into
// a two-entry queue, the next stage looks it up in the parallel range table, and the
// last stage adds it to the sums and registers the result. The range table lookup is
// the longest path. The user must write configuration only while the block is idle;
// the block does not enforce it. Writes to an unused index are ignored.
module utf8_display_width_tracker #(
    parameter int TOTAL_BITS = u8w_pkg::TOTAL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // final_byte
    // Character results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] char_width, [23:3] code_point, [39:24] running_width, [40] keep,
    // [47:41] zero
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // [0] well_formed
    output logic        o_m_axis_tlast,   // string_end
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic               r_narrow;
    logic [1:0]         r_emoji;
    logic [11:0]        r_max_cols;
    u8w_pkg::t_cfg      cfg;

    logic               fe_valid, fe_ready;
    u8w_pkg::t_char_evt fe_evt;
    logic               q_valid, q_ready;
    u8w_pkg::t_char_evt q_evt;
    u8w_pkg::t_result   result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow   <= u8w_pkg::NARROW_RST;
            r_emoji    <= u8w_pkg::EMOJI_RST;
            r_max_cols <= u8w_pkg::MAX_COL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                u8w_pkg::CFG_NARROW_AMBIGUOUS: r_narrow   <= i_cfg_data[0];
                u8w_pkg::CFG_EMOJI_COLUMNS:    r_emoji    <= i_cfg_data[1:0];
                u8w_pkg::CFG_MAX_COLUMNS:      r_max_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.narrow_ambiguous = r_narrow;
    assign cfg.emoji_columns    = r_emoji;
    assign cfg.max_columns      = r_max_cols;

    u8w_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_final     (i_s_axis_tlast),
        .o_evt_valid (fe_valid),
        .i_evt_ready (fe_ready),
        .o_evt       (fe_evt)
    );

    u8w_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_data  (fe_evt),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_evt)
    );

    u8w_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_evt_valid (q_valid),
        .o_evt_ready (q_ready),
        .i_evt       (q_evt),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (result)
    );

    // Result packing
    assign o_m_axis_tdata = {7'd0, result.keep, result.running_width,
                             result.code_point, result.char_width};
    assign o_m_axis_tuser = result.well_formed;
    assign o_m_axis_tlast = result.string_end;

endmodule

// ----- rtl/u8w_checker.sv -----
// Port-level checks of the UTF-8 display width tracker, bound to the top level.
module u8w_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
            $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // No result in the cycle after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Malformed characters are one column and carry a lead byte
    a_bad_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[2:0] == 3'd1 && o_m_axis_tdata[23:11] == 13'd0)
        else $error("malformed character with wrong width or code point");

    // C0 controls other than NUL are minus one column
    a_ctrl_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser && o_m_axis_tdata[23:8] == 16'd0 &&
        o_m_axis_tdata[10:3] != 8'd0 && o_m_axis_tdata[10:8] == 3'd0 |->
            o_m_axis_tdata[2:0] == 3'b111)
        else $error("control character width is not minus one");

endmodule

bind utf8_display_width_tracker u8w_checker u_u8w_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
